// ----- rtl/hts_pkg.sv -----
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, codes and the check-byte helper for the sample decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

  // command codes
  localparam logic [1:0] CMD_HUMIDITY  = 2'd0;
  localparam logic [1:0] CMD_TEMP      = 2'd1;
  localparam logic [1:0] CMD_TEMP_HUM  = 2'd2;
  localparam logic [1:0] CMD_ADC       = 2'd3;

  // register indexes
  localparam logic REG_RESOLUTION = 1'b0;
  localparam logic REG_FILTER     = 1'b1;

  // resolution codes
  localparam logic [1:0] RES_FULL = 2'd0;
  localparam logic [1:0] RES_LOW  = 2'd1;

  localparam logic [7:0]  CRC_POLY   = 8'h31;
  localparam logic [15:0] TEMP_MASK  = 16'hFFFC;
  localparam logic [10:0] HUM_SCALE  = 11'd1250;
  localparam logic [14:0] TEMP_SCALE = 15'd17572;
  localparam logic [12:0] TEMP_OFFS  = 13'd4685;
  localparam logic [5:0]  HUM_OFFS   = 6'd60;
  localparam logic [9:0]  HUM_MAX    = 10'd1000;
  localparam logic [7:0]  RECIP10_11 = 8'd205;      // 2^11 / 10, exact below 1029
  localparam logic [15:0] RECIP10_19 = 16'd52429;   // 2^19 / 10, exact for 16 bits
  localparam logic [23:0] ACC_MAX    = 24'hFFFFFF;

  // decoded item between the two stages
  typedef struct packed {
    logic [1:0]         cmd;
    logic               crc_ok;
    logic [9:0]         hum;     // tenths of percent, clamped
    logic signed [14:0] temp;    // hundredths of degree
    logic [15:0]        raw;
  } front_t;

  // one byte of the msb-first crc, polynomial x^8+x^5+x^4+1
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/humidity_temp_sample_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// humidity_temp_sample_decoder_unit
// Decodes raw humidity, temperature and adc words into scaled results.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries cmd, raw_word and check_byte;
//   output channel out_valid/out_ready carries status, measurement, adc_sum.
//   one result beat per input beat, in order.
//   each input beat passes the decode stage register, then the output
//   register; throughput one beat per cycle while out_ready stays high, set by
//   the two-stage pipeline with the adc running sum closed over the output stage.
//   the check byte test and scaling multiplies sit in the decode stage, the
//   divide-by-ten rounding and the running sum in the output stage.
//   when out_ready is low the output beat holds; the decode stage still
//   takes a new beat while it is empty, then in_ready drops.
//   reset clears both stage valids, the adc sum and the two registers
//   (full resolution, no averaging shift).
//   cfg_write with cfg_index/cfg_data writes a register in the same cycle;
//   write only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_sample_decoder_unit
  import hts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         cmd,
  input  wire logic [15:0]        raw_word,
  input  wire logic [7:0]         check_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    status,
  output logic signed [14:0]      measurement,
  output logic [23:0]             adc_sum,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [3:0]         cfg_data
);

  logic [1:0] resolution_mode;
  logic [3:0] avg_shift;
  logic       advance;
  logic       stage_valid;
  front_t     stage;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution_mode <= RES_FULL;
      avg_shift       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RESOLUTION: resolution_mode <= cfg_data[1:0];
        REG_FILTER:     avg_shift       <= cfg_data;
        default:        ;
      endcase
    end
  end

  hts_front u_front (
    .clk         (clk),
    .rst         (rst),
    .load        (in_ready),
    .accept      (in_valid && in_ready),
    .in_valid    (in_valid),
    .cmd         (cmd),
    .raw_word    (raw_word),
    .check_byte  (check_byte),
    .stage       (stage),
    .stage_valid (stage_valid)
  );

  hts_back u_back (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .stage_valid     (stage_valid),
    .stage           (stage),
    .resolution_mode (resolution_mode),
    .avg_shift       (avg_shift),
    .out_valid       (out_valid),
    .status          (status),
    .measurement     (measurement),
    .adc_sum         (adc_sum)
  );

endmodule

`default_nettype wire

// ----- rtl/hts_front.sv -----
// ----------------------------------------------------------------------------
// hts_front
// Check byte test and scaling multiplies, registered into the decode stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_front
  import hts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic        accept,
  input  wire logic        in_valid,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] raw_word,
  input  wire logic [7:0]  check_byte,
  output front_t           stage,
  output logic             stage_valid
);

  logic [7:0]         crc;
  logic [15:0]        temp_raw;
  logic [26:0]        hum_prod;
  logic [30:0]        temp_prod;
  logic signed [11:0] hum_off;
  logic [9:0]         hum_clamped;
  logic signed [15:0] temp_off;
  front_t             stage_next;

  always_comb begin
    crc       = crc_byte(crc_byte(8'h00, raw_word[15:8]), raw_word[7:0]);
    temp_raw  = (cmd == CMD_TEMP) ? (raw_word & TEMP_MASK) : raw_word;
    hum_prod  = 27'(raw_word) * 27'(HUM_SCALE);
    temp_prod = 31'(temp_raw) * 31'(TEMP_SCALE);
    hum_off   = $signed({1'b0, hum_prod[26:16]}) - $signed({6'd0, HUM_OFFS});
    if (hum_off < 0) begin
      hum_clamped = '0;
    end else if (hum_off > $signed({2'b00, HUM_MAX})) begin
      hum_clamped = HUM_MAX;
    end else begin
      hum_clamped = hum_off[9:0];
    end
    temp_off = $signed({1'b0, temp_prod[30:16]}) - $signed({3'd0, TEMP_OFFS});

    stage_next.cmd    = cmd;
    stage_next.crc_ok = (crc == check_byte);
    stage_next.hum    = hum_clamped;
    stage_next.temp   = temp_off[14:0];
    stage_next.raw    = raw_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hts_back.sv -----
// ----------------------------------------------------------------------------
// hts_back
// Rounding, result selection and the adc running sum; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_back
  import hts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic               stage_valid,
  input  front_t                  stage,
  input  wire logic [1:0]         resolution_mode,
  input  wire logic [3:0]         avg_shift,
  output logic                    out_valid,
  output logic                    status,
  output logic signed [14:0]      measurement,
  output logic [23:0]             adc_sum
);

  logic [10:0]        hum_plus;
  logic [18:0]        hum_prod;
  logic [6:0]         hum_q;
  logic [9:0]         hum_round;
  logic               temp_neg;
  logic [13:0]        temp_mag;
  logic [29:0]        temp_prod;
  logic [10:0]        temp_q;
  logic [13:0]        temp_tens;
  logic signed [14:0] temp_round;
  logic signed [14:0] hum_val;
  logic signed [14:0] temp_val;
  logic [24:0]        acc_sum;
  logic [23:0]        acc_next;
  logic               status_next;
  logic signed [14:0] meas_next;
  logic               load;

  assign load = advance && stage_valid;

  always_comb begin
    // humidity to whole percent
    hum_plus  = {1'b0, stage.hum} + 11'd5;
    hum_prod  = 19'(hum_plus) * 19'(RECIP10_11);
    hum_q     = hum_prod[17:11];
    hum_round = 10'({hum_q, 3'b000}) + 10'({hum_q, 1'b0});
    hum_val   = (resolution_mode == RES_LOW) ? $signed({5'd0, hum_round})
                                             : $signed({5'd0, stage.hum});

    // temperature to tenths, half away from zero
    temp_neg   = (stage.temp <= 0);
    temp_mag   = temp_neg ? 14'(-stage.temp) : stage.temp[13:0];
    temp_mag   = temp_mag + 14'd5;
    temp_prod  = 30'(temp_mag) * 30'(RECIP10_19);
    temp_q     = temp_prod[29:19];
    temp_tens  = 14'({temp_q, 3'b000}) + 14'({temp_q, 1'b0});
    temp_round = temp_neg ? -$signed({1'b0, temp_tens}) : $signed({1'b0, temp_tens});
    temp_val   = (resolution_mode != RES_FULL) ? temp_round : stage.temp;

    // running sum, acc - (acc >> n) never goes negative
    acc_sum  = {1'b0, adc_sum} + 25'(stage.raw) - 25'(adc_sum >> avg_shift);
    acc_next = acc_sum[24] ? ACC_MAX : acc_sum[23:0];

    status_next = 1'b0;
    meas_next   = '0;
    case (stage.cmd)
      CMD_HUMIDITY: begin
        status_next = !stage.crc_ok;
        meas_next   = stage.crc_ok ? hum_val : '0;
      end
      CMD_TEMP: begin
        status_next = !stage.crc_ok;
        meas_next   = stage.crc_ok ? temp_val : '0;
      end
      CMD_TEMP_HUM: begin
        meas_next = temp_val;
      end
      default: begin
        meas_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      adc_sum   <= '0;
    end else begin
      if (advance) begin
        out_valid <= stage_valid;
      end
      if (load && stage.cmd == CMD_ADC) begin
        adc_sum <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= status_next;
      measurement <= meas_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hts_checker.sv -----
// ----------------------------------------------------------------------------
// hts_checker
// Port-level checks on the sample decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         cmd,
  input wire logic [15:0]        raw_word,
  input wire logic [7:0]         check_byte,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               status,
  input wire logic signed [14:0] measurement,
  input wire logic [23:0]        adc_sum
);

  // a waiting input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(raw_word)
      && $stable(check_byte))
    else $error("input beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(measurement) && $stable(status)
      && $stable(adc_sum))
    else $error("result beat changed while stalled");

  // a check byte mismatch reports no value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> measurement == 15'sd0)
    else $error("measurement not zero on mismatch");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> measurement >= -15'sd4690 && measurement <= 15'sd12890)
    else $error("measurement out of range");

  // nothing left over from before reset
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && adc_sum == 24'd0)
    else $error("pipeline not empty after reset");

endmodule

bind humidity_temp_sample_decoder_unit hts_checker u_hts_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_humidity_temp_sample_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_humidity_temp_sample_decoder_unit
// Self-checking bench for the humidity / temperature sample decoder. Every
// accepted input beat is decoded by a bit-exact predictor, and each result
// beat is matched in order against it. The run starts with a directed set
// (field extremes, bad check bytes, the rounding region around zero degrees,
// adc full-scale words), then randomised phases over several register settings.
// The randomised phases use sender gaps, receiver stalls and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_humidity_temp_sample_decoder_unit;
  import hts_pkg::*;

  localparam int QUIET_LIMIT = 4000;   // cycles with no beat on either side
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic               status;
    logic signed [14:0] measurement;
    logic [23:0]        adc_sum;
  } reading_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_profile_t;

  class reading_ledger;
    localparam logic [23:0] CRC_DIVISOR = 24'h988000;

    logic [1:0]  res_mode;
    logic [3:0]  filt_pow;
    logic [23:0] adc_acc;
    reading_t    due_readings[$];
    int          errors;
    int          beats;
    int          crc_rejects;
    int          saturations;

    function new();
      res_mode    = RES_FULL;
      filt_pow    = 4'd0;
      adc_acc     = 24'd0;
      errors      = 0;
      beats       = 0;
      crc_rejects = 0;
      saturations = 0;
    endfunction

    // long division by x^8+x^5+x^4+1 over data then check byte
    static function logic [7:0] crc_residue(logic [15:0] data, logic [7:0] chk);
      logic [23:0] rem;
      logic [23:0] dvs;
      rem = {data, chk};
      dvs = CRC_DIVISOR;
      for (int i = 0; i < 16; i++) begin
        if (rem[23 - i]) rem ^= dvs;
        dvs >>= 1;
      end
      return rem[7:0];
    endfunction

    function void set_register(logic idx, logic [3:0] data);
      if (idx == REG_RESOLUTION) res_mode = data[1:0];
      else filt_pow = data;
    endfunction

    function int humidity_tenths(logic [15:0] raw);
      int h;
      h = ((int'(HUM_SCALE) * int'(raw)) >>> 16) - int'(HUM_OFFS);
      if (h > int'(HUM_MAX)) h = int'(HUM_MAX);
      if (h < 0) h = 0;
      if (res_mode == RES_LOW) h = ((h + 5) / 10) * 10;
      return h;
    endfunction

    function int temp_hundredths(logic [15:0] raw);
      int t;
      t = ((int'(TEMP_SCALE) * int'(raw)) >>> 16) - int'(TEMP_OFFS);
      if (res_mode != RES_FULL) begin
        // round to tenths away from zero, division truncates
        if (t > 0) t = (t + 5) / 10;
        else t = (t - 5) / 10;
        t = t * 10;
      end
      return t;
    endfunction

    function void take_sample(logic [1:0] cmd, logic [15:0] raw, logic [7:0] chk);
      reading_t    r;
      logic [31:0] next_acc;
      r.status      = 1'b0;
      r.measurement = '0;
      beats++;
      case (cmd)
        CMD_HUMIDITY, CMD_TEMP: begin
          if (crc_residue(raw, chk) != 8'd0) begin
            r.status = 1'b1;
            crc_rejects++;
          end else if (cmd == CMD_HUMIDITY) begin
            r.measurement = 15'(humidity_tenths(raw));
          end else begin
            r.measurement = 15'(temp_hundredths(raw & TEMP_MASK));
          end
        end
        CMD_TEMP_HUM: begin
          r.measurement = 15'(temp_hundredths(raw));
        end
        default: begin
          next_acc = {8'd0, adc_acc} + {16'd0, raw} - {8'd0, adc_acc >> filt_pow};
          if (next_acc > {8'd0, ACC_MAX}) begin
            next_acc = {8'd0, ACC_MAX};
            saturations++;
          end
          adc_acc = next_acc[23:0];
        end
      endcase
      r.adc_sum = adc_acc;
      due_readings.push_back(r);
    endfunction

    function void match_reading(logic status, logic signed [14:0] measurement,
                                logic [23:0] adc_sum);
      reading_t e;
      if (due_readings.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d measurement %0d adc_sum %0d",
               status, measurement, adc_sum);
        errors++;
        return;
      end
      e = due_readings.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (measurement !== e.measurement) begin
        $error("measurement: expected %0d, got %0d", e.measurement, measurement);
        errors++;
      end
      if (adc_sum !== e.adc_sum) begin
        $error("adc_sum: expected %0d, got %0d", e.adc_sum, adc_sum);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         cmd;
  logic [15:0]        raw_word;
  logic [7:0]         check_byte;
  logic               out_valid;
  logic               out_ready;
  logic               status;
  logic signed [14:0] measurement;
  logic [23:0]        adc_sum;
  logic               cfg_write;
  logic               cfg_index;
  logic [3:0]         cfg_data;

  reading_ledger ledger = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int quiet_cycles;

  logic [1:0] sensor_cmds[3] = '{CMD_HUMIDITY, CMD_TEMP, CMD_TEMP_HUM};

  humidity_temp_sample_decoder_unit uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .raw_word    (raw_word),
    .check_byte  (check_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .measurement (measurement),
    .adc_sum     (adc_sum),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: stalls per phase, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready    = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) ledger.match_reading(status, measurement, adc_sum);
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_item(input logic [1:0] c, input logic [15:0] r, input logic [7:0] k);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    cmd        = c;
    raw_word   = r;
    check_byte = k;
    do @(posedge clk); while (!in_ready);
    ledger.take_sample(c, r, k);
    @(negedge clk);
  endtask

  task automatic send_sensor(input logic [1:0] c, input logic [15:0] r, input bit corrupt);
    logic [7:0] k;
    k = reading_ledger::crc_residue(r, 8'h00) ^ (corrupt ? 8'h5A : 8'h00);
    send_item(c, r, k);
  endtask

  task automatic settle_and_configure(input logic [3:0] mode_data, input logic [3:0] fp);
    while (ledger.due_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = REG_RESOLUTION;
    cfg_data  = mode_data;
    @(negedge clk);
    cfg_index = REG_FILTER;
    cfg_data  = fp;
    @(negedge clk);
    cfg_write = 1'b0;
    ledger.set_register(REG_RESOLUTION, mode_data);
    ledger.set_register(REG_FILTER, fp);
  endtask

  task automatic run_phase(input logic [3:0] mode_data, input logic [3:0] fp,
                           input idle_profile_t idling, input int count,
                           input int adc_pct, input bit squeeze);
    logic [1:0]  c;
    logic [15:0] r;
    logic [7:0]  k;
    int          sel;
    settle_and_configure(mode_data, fp);
    send_idle_pct  = (idling == IDLE_SENDER) ? 59 : (idling == IDLE_BOTH) ? 21 : 0;
    recv_stall_pct = (idling == IDLE_RECEIVER) ? 59 : (idling == IDLE_BOTH) ? 21 : 0;
    for (int n = 0; n < count; n++) begin
      if (squeeze && n == count / 4) hold_request = 1'b1;
      if ($urandom_range(99) < adc_pct) c = CMD_ADC;
      else c = sensor_cmds[$urandom_range(2)];
      sel = $urandom_range(15);
      if (c == CMD_ADC && adc_pct >= 50 && sel < 12) begin
        r = 16'($urandom_range(16'hFFFF, 16'hF000));
      end else begin
        case (sel)
          0: r = 16'h0000;
          1: r = 16'hFFFF;
          2: r = 16'($urandom_range(17520, 17420));   // around zero degrees
          3: r = 16'($urandom_range(63));
          default: r = 16'($urandom);
        endcase
      end
      k = 8'($urandom);
      if ((c == CMD_HUMIDITY || c == CMD_TEMP) && $urandom_range(9) < 8)
        k = reading_ledger::crc_residue(r, 8'h00);
      send_item(c, r, k);
    end
    in_valid = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = CMD_HUMIDITY;
    raw_word   = '0;
    check_byte = '0;
    cfg_write  = 1'b0;
    cfg_index  = REG_RESOLUTION;
    cfg_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed beats at reset settings: clamps, masking, bad check bytes
    send_sensor(CMD_HUMIDITY, 16'h0000, 1'b0);
    send_sensor(CMD_HUMIDITY, 16'hFFFF, 1'b0);
    send_sensor(CMD_HUMIDITY, 16'h8000, 1'b0);
    send_sensor(CMD_HUMIDITY, 16'h6A3C, 1'b1);
    send_sensor(CMD_TEMP, 16'h0000, 1'b0);
    send_sensor(CMD_TEMP, 16'hFFFF, 1'b0);
    send_sensor(CMD_TEMP, 16'h0003, 1'b0);
    send_sensor(CMD_TEMP, 16'hC5D2, 1'b1);
    send_sensor(CMD_TEMP_HUM, 16'd17474, 1'b1);
    send_sensor(CMD_TEMP_HUM, 16'd17468, 1'b0);
    send_sensor(CMD_TEMP_HUM, 16'hFFFF, 1'b0);
    send_sensor(CMD_ADC, 16'hFFFF, 1'b0);
    send_sensor(CMD_ADC, 16'h0000, 1'b1);
    in_valid = 1'b0;

    // reduced resolution: rounding either side of zero and near the top
    settle_and_configure(4'd1, 4'd8);
    send_sensor(CMD_HUMIDITY, 16'hFFFF, 1'b0);
    send_sensor(CMD_HUMIDITY, 16'd55313, 1'b0);
    send_sensor(CMD_TEMP_HUM, 16'd17474, 1'b0);
    send_sensor(CMD_TEMP_HUM, 16'd17440, 1'b0);
    send_sensor(CMD_TEMP_HUM, 16'd17510, 1'b0);
    send_sensor(CMD_TEMP, 16'h4444, 1'b0);
    send_sensor(CMD_ADC, 16'hFFFF, 1'b0);
    send_sensor(CMD_ADC, 16'hFFFF, 1'b0);
    send_sensor(CMD_ADC, 16'hFFFF, 1'b0);
    send_sensor(CMD_ADC, 16'h1234, 1'b0);
    in_valid = 1'b0;

    run_phase(4'd0,  4'd0,  IDLE_NONE,     130, 25, 1'b0);
    run_phase(4'd1,  4'd8,  IDLE_SENDER,   130, 25, 1'b0);
    run_phase(4'd2,  4'd3,  IDLE_RECEIVER, 130, 25, 1'b1);
    // long filter windows with heavy adc traffic drive the sum into saturation
    run_phase(4'd3,  4'd15, IDLE_BOTH,     260, 90, 1'b0);
    run_phase(4'd13, 4'd12, IDLE_NONE,     200, 90, 1'b0);
    run_phase(4'd0,  4'd1,  IDLE_SENDER,   130, 25, 1'b0);
    run_phase(4'd1,  4'd0,  IDLE_RECEIVER, 130, 25, 1'b0);
    run_phase(4'd3,  4'd8,  IDLE_BOTH,     130, 40, 1'b0);

    while (ledger.due_readings.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (ledger.due_readings.size() != 0) begin
      $error("%0d results never arrived", ledger.due_readings.size());
      ledger.errors++;
    end

    $display("summary: %0d beats over 10 register settings, %0d with a failing check byte",
             ledger.beats, ledger.crc_rejects);
    $display("summary: adc sum clipped on %0d beats, one %0d-cycle receiver hold-off",
             ledger.saturations, HOLD_CYCLES);
    if (ledger.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
